// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int KIND_W  = 2;
  localparam int PRIO_W  = 2;
  localparam int AGE_W   = 8;
  localparam int ARR_W   = 16;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPRIO = 2'd3;

  localparam logic [PRIO_W-1:0] PRIO_NONE = 2'd0;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } op_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [AGE_W-1:0]  age;
    logic [ARR_W-1:0]  arrival;
  } entry_t;

  typedef struct packed {
    op_t                op;
    entry_t             fresh;
    logic [COUNT_W-1:0] occ;
  } ctl_t;

  typedef struct packed {
    logic ins;
    logic hit;
  } cell_stat_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// One queue slot: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic                         clk,
  input  spq_pkg::ctl_t                ctl,
  input  logic [spq_pkg::COUNT_W-1:0]  idx,
  input  spq_pkg::entry_t              left,
  input  spq_pkg::entry_t              right,
  input  spq_pkg::entry_t              head,
  input  logic                         ins_left,
  output spq_pkg::entry_t              ent,
  output spq_pkg::cell_stat_t          stat
);

  spq_pkg::entry_t ent_next;
  logic            occupied;

  // Slots past the tail always count as behind the insert point.
  assign occupied = idx < ctl.occ;
  assign stat.ins = !occupied || (ent.prio > ctl.fresh.prio);
  assign stat.hit = stat.ins && !ins_left;

  always_comb begin
    case (ctl.op)
      spq_pkg::OP_HOLD:   ent_next = ent;
      spq_pkg::OP_INSERT: begin
        if (stat.hit) ent_next = ctl.fresh;
        else if (stat.ins) ent_next = left;
        else ent_next = ent;
      end
      spq_pkg::OP_REMOVE: ent_next = right;
      // Tail slot wraps the head around so the list restores order.
      spq_pkg::OP_ROTATE: ent_next = ((idx + 7'd1) == ctl.occ) ? head : right;
      default:            ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ----- rtl/core/stable_priority_queue.sv -----
// Insert and remove: result in the cycle after the input beat; a new beat may follow in the next
// cycle unless the result is stalled. List of N entries: one result beat per cycle unless stalled,
// the first once the state and output registers load; no new input until the last beat is out;
// an empty queue answers in the cycle after the input beat. Output stalls hold the slot chain.
// Reset clears the entry count, the arrival counter and the output valid; slots are not cleared.
module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spq_pkg::KIND_W-1:0]    kind,
  input  logic [spq_pkg::PRIO_W-1:0]    new_priority,
  input  logic [spq_pkg::AGE_W-1:0]     new_age,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spq_pkg::STAT_W-1:0]    status,
  output logic [spq_pkg::POS_W-1:0]     position,
  output logic [spq_pkg::PRIO_W-1:0]    entry_priority,
  output logic [spq_pkg::AGE_W-1:0]     entry_age,
  output logic [spq_pkg::ARR_W-1:0]     entry_arrival,
  output logic [spq_pkg::COUNT_W-1:0]   entry_count,
  output logic                          last
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t                        state;
  logic [spq_pkg::COUNT_W-1:0]   occ;
  logic [spq_pkg::ARR_W-1:0]     arr_cnt;
  logic [spq_pkg::POS_W-1:0]     list_idx;

  spq_pkg::ctl_t                 ctl;
  spq_pkg::entry_t               ent  [DEPTH];
  spq_pkg::cell_stat_t           stat [DEPTH];
  logic [spq_pkg::POS_W-1:0]     ins_pos;
  logic [spq_pkg::ARR_W-1:0]     arr_inc;
  logic                          take;
  logic                          out_free;
  logic                          full;
  logic                          list_last;

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full      = occ >= spq_pkg::COUNT_W'(DEPTH);
  assign arr_inc   = arr_cnt + 16'd1;
  assign list_last = ({1'b0, list_idx} + 7'd1) == occ;

  always_comb begin
    ctl.op    = spq_pkg::OP_HOLD;
    ctl.fresh = '{prio: new_priority, age: new_age, arrival: arr_inc};
    ctl.occ   = occ;
    if (take) begin
      case (kind)
        spq_pkg::KIND_INSERT:
          if (!full && new_priority != spq_pkg::PRIO_NONE) ctl.op = spq_pkg::OP_INSERT;
        spq_pkg::KIND_REMOVE:
          if (occ != '0) ctl.op = spq_pkg::OP_REMOVE;
        default: ctl.op = spq_pkg::OP_HOLD;
      endcase
    end else if (state == S_LIST && out_free) begin
      ctl.op = spq_pkg::OP_ROTATE;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            ins_left;

    if (g == 0) begin : g_first
      assign left_ent = ent[g];
      assign ins_left = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[g-1];
      assign ins_left = stat[g-1].ins;
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_ent = ent[g];
    end else begin : g_body
      assign right_ent = ent[g+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (spq_pkg::COUNT_W'(g)),
      .left     (left_ent),
      .right    (right_ent),
      .head     (ent[0]),
      .ins_left (ins_left),
      .ent      (ent[g]),
      .stat     (stat[g])
    );
  end

  // At most one slot flags the insert point (exactly one unless full); fold its index out.
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (stat[i].hit) ins_pos = ins_pos | spq_pkg::POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      arr_cnt   <= '0;
      list_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            position       <= '0;
            entry_priority <= spq_pkg::PRIO_NONE;
            entry_age      <= '0;
            entry_arrival  <= '0;
            entry_count    <= occ;
            last           <= 1'b1;
            case (kind)
              spq_pkg::KIND_INSERT: begin
                out_valid <= 1'b1;
                if (full) begin
                  status <= spq_pkg::ST_FULL;
                end else if (new_priority == spq_pkg::PRIO_NONE) begin
                  status <= spq_pkg::ST_BADPRIO;
                end else begin
                  status         <= spq_pkg::ST_OK;
                  position       <= ins_pos;
                  entry_priority <= new_priority;
                  entry_age      <= new_age;
                  entry_arrival  <= arr_inc;
                  entry_count    <= occ + 7'd1;
                  occ            <= occ + 7'd1;
                  arr_cnt        <= arr_inc;
                end
              end
              spq_pkg::KIND_REMOVE: begin
                out_valid <= 1'b1;
                if (occ == '0) begin
                  status <= spq_pkg::ST_EMPTY;
                end else begin
                  status         <= spq_pkg::ST_OK;
                  entry_priority <= ent[0].prio;
                  entry_age      <= ent[0].age;
                  entry_arrival  <= ent[0].arrival;
                  entry_count    <= occ - 7'd1;
                  occ            <= occ - 7'd1;
                end
              end
              spq_pkg::KIND_LIST: begin
                if (occ == '0) begin
                  out_valid <= 1'b1;
                  status    <= spq_pkg::ST_EMPTY;
                end else begin
                  state    <= S_LIST;
                  list_idx <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_LIST: begin
          // Emit the head and rotate; after occ beats the order is restored.
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= spq_pkg::ST_OK;
            position       <= list_idx;
            entry_priority <= ent[0].prio;
            entry_age      <= ent[0].age;
            entry_arrival  <= ent[0].arrival;
            entry_count    <= occ;
            last           <= list_last;
            if (list_last) state <= S_IDLE;
            else list_idx <= list_idx + 6'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/spq_check.sv -----
// Port-level checks for the stable priority queue, bound to the top level.
module spq_check #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [spq_pkg::STAT_W-1:0]    status,
  input logic [spq_pkg::PRIO_W-1:0]    entry_priority,
  input logic [spq_pkg::COUNT_W-1:0]   entry_count,
  input logic                          last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != spq_pkg::ST_OK |-> last)
    else $error("error result not flagged last");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_EMPTY |-> entry_count == '0)
    else $error("empty result with nonzero count");

  a_ok_prio: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_OK |-> entry_priority != spq_pkg::PRIO_NONE)
    else $error("ok result without a priority");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_FULL |-> entry_count == spq_pkg::COUNT_W'(DEPTH))
    else $error("full result below capacity");

endmodule

bind stable_priority_queue spq_check #(.DEPTH(DEPTH)) u_spq_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .entry_priority (entry_priority),
  .entry_count    (entry_count),
  .last           (last)
);

// ----- bench/stable_priority_queue_tb.sv -----
// Self-checking bench for the stable priority queue: directed and random traffic.
module stable_priority_queue_tb;

  localparam int DEPTH        = spq_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 310;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
  localparam int WATCHDOG     = 4000;

  // the one kind value the block ignores
  localparam logic [spq_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [spq_pkg::STAT_W-1:0]  status;
    logic [spq_pkg::POS_W-1:0]   position;
    logic [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::AGE_W-1:0]   age;
    logic [spq_pkg::ARR_W-1:0]   arrival;
    logic [spq_pkg::COUNT_W-1:0] count;
    logic                        last;
  } answer_t;

  class queue_book;
    logic [spq_pkg::PRIO_W-1:0] slot_prio[DEPTH];
    logic [spq_pkg::AGE_W-1:0]  slot_age[DEPTH];
    logic [spq_pkg::ARR_W-1:0]  slot_arrival[DEPTH];
    int                         fill;
    logic [spq_pkg::ARR_W-1:0]  ticket;
    answer_t                    answers_due[$];
    int                         errors;

    function new();
      fill   = 0;
      ticket = '0;
      errors = 0;
    endfunction

    // Predict every answer that one accepted request beat causes.
    function void take_request(logic [spq_pkg::KIND_W-1:0] k,
                               logic [spq_pkg::PRIO_W-1:0] p,
                               logic [spq_pkg::AGE_W-1:0] a);
      answer_t r;
      int      pos;
      int      i;
      r      = '0;
      r.last = 1'b1;
      case (k)
        spq_pkg::KIND_INSERT: begin
          r.count = spq_pkg::COUNT_W'(fill);
          if (fill >= DEPTH) begin
            r.status = spq_pkg::ST_FULL;
          end else if (p == spq_pkg::PRIO_NONE) begin
            r.status = spq_pkg::ST_BADPRIO;
          end else begin
            ticket++;
            pos = fill;
            // go behind every entry of equal or more urgent priority
            for (i = fill - 1; i >= 0; i--)
              if (slot_prio[i] > p) pos = i;
            for (i = fill; i > pos; i--) begin
              slot_prio[i]    = slot_prio[i-1];
              slot_age[i]     = slot_age[i-1];
              slot_arrival[i] = slot_arrival[i-1];
            end
            slot_prio[pos]    = p;
            slot_age[pos]     = a;
            slot_arrival[pos] = ticket;
            fill++;
            r.status   = spq_pkg::ST_OK;
            r.position = spq_pkg::POS_W'(pos);
            r.prio     = p;
            r.age      = a;
            r.arrival  = ticket;
            r.count    = spq_pkg::COUNT_W'(fill);
          end
          answers_due.push_back(r);
        end
        spq_pkg::KIND_REMOVE: begin
          if (fill == 0) begin
            r.status = spq_pkg::ST_EMPTY;
          end else begin
            r.status  = spq_pkg::ST_OK;
            r.prio    = slot_prio[0];
            r.age     = slot_age[0];
            r.arrival = slot_arrival[0];
            for (i = 0; i + 1 < fill; i++) begin
              slot_prio[i]    = slot_prio[i+1];
              slot_age[i]     = slot_age[i+1];
              slot_arrival[i] = slot_arrival[i+1];
            end
            fill--;
            r.count = spq_pkg::COUNT_W'(fill);
          end
          answers_due.push_back(r);
        end
        spq_pkg::KIND_LIST: begin
          if (fill == 0) begin
            r.status = spq_pkg::ST_EMPTY;
            answers_due.push_back(r);
          end else begin
            for (i = 0; i < fill; i++) begin
              r.status   = spq_pkg::ST_OK;
              r.position = spq_pkg::POS_W'(i);
              r.prio     = slot_prio[i];
              r.age      = slot_age[i];
              r.arrival  = slot_arrival[i];
              r.count    = spq_pkg::COUNT_W'(fill);
              r.last     = (i == fill - 1);
              answers_due.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result beat with the oldest answer due.
    function void check_answer(answer_t got);
      answer_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: result beat with none due: expected none actual %p", $time, got);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("position", 16'(want.position), 16'(got.position));
      check_field("entry_priority", 16'(want.prio), 16'(got.prio));
      check_field("entry_age", 16'(want.age), 16'(got.age));
      check_field("entry_arrival", want.arrival, got.arrival);
      check_field("entry_count", 16'(want.count), 16'(got.count));
      check_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic [spq_pkg::KIND_W-1:0]    kind         = '0;
  logic [spq_pkg::PRIO_W-1:0]    new_priority = '0;
  logic [spq_pkg::AGE_W-1:0]     new_age      = '0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic [spq_pkg::STAT_W-1:0]    status;
  logic [spq_pkg::POS_W-1:0]     position;
  logic [spq_pkg::PRIO_W-1:0]    entry_priority;
  logic [spq_pkg::AGE_W-1:0]     entry_age;
  logic [spq_pkg::ARR_W-1:0]     entry_arrival;
  logic [spq_pkg::COUNT_W-1:0]   entry_count;
  logic                          last;

  queue_book book = new();
  bit        calm     = 1'b1;
  bit        hold_req = 1'b0;
  int        burst_left = 0;

  stable_priority_queue #(.DEPTH(DEPTH)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .new_priority   (new_priority),
    .new_age        (new_age),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .position       (position),
    .entry_priority (entry_priority),
    .entry_age      (entry_age),
    .entry_arrival  (entry_arrival),
    .entry_count    (entry_count),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) book.take_request(kind, new_priority, new_age);
      if (out_valid && !out_stall)
        book.check_answer('{status, position, entry_priority, entry_age,
                            entry_arrival, entry_count, last});
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (calm)
        out_stall <= 1'b0;
      else
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("stable_priority_queue: mismatch");
    $finish;
  end

  // Offer one beat and hold it until accepted; open a new burst, often after a gap, when due.
  task automatic send_beat(input logic [spq_pkg::KIND_W-1:0] k,
                           input logic [spq_pkg::PRIO_W-1:0] p,
                           input logic [spq_pkg::AGE_W-1:0] a);
    int gap;
    if (!calm) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid     <= 1'b1;
    kind         <= k;
    new_priority <= p;
    new_age      <= a;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_request(input int insert_pct, input int remove_pct,
                                output logic [spq_pkg::KIND_W-1:0] k);
    int                         roll;
    logic [spq_pkg::PRIO_W-1:0] p;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) k = spq_pkg::KIND_INSERT;
    else if (roll < insert_pct + remove_pct) k = spq_pkg::KIND_REMOVE;
    else if (roll < 96) k = spq_pkg::KIND_LIST;
    else k = KIND_SPARE;
    p = ($urandom_range(0, 9) == 0) ? spq_pkg::PRIO_NONE
                                    : spq_pkg::PRIO_W'($urandom_range(1, 3));
    send_beat(k, p, spq_pkg::AGE_W'($urandom));
  endtask

  initial begin
    logic [spq_pkg::KIND_W-1:0] k;
    int                         done;
    int                         overrun;
    bit                         filling;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, bad priority, ignored kind, FIFO ties, age extremes
    send_beat(spq_pkg::KIND_REMOVE, spq_pkg::PRIO_NONE, 8'h00);
    send_beat(spq_pkg::KIND_LIST, spq_pkg::PRIO_NONE, 8'h00);
    send_beat(spq_pkg::KIND_INSERT, spq_pkg::PRIO_NONE, 8'hFF);
    send_beat(KIND_SPARE, 2'd3, 8'hAA);
    send_beat(spq_pkg::KIND_INSERT, 2'd3, 8'hFF);
    send_beat(spq_pkg::KIND_INSERT, 2'd3, 8'h00);
    send_beat(spq_pkg::KIND_INSERT, 2'd1, 8'h11);
    send_beat(spq_pkg::KIND_INSERT, 2'd2, 8'h22);
    send_beat(spq_pkg::KIND_INSERT, 2'd1, 8'h33);
    send_beat(spq_pkg::KIND_INSERT, 2'd2, 8'h80);
    send_beat(spq_pkg::KIND_INSERT, 2'd3, 8'h7F);
    send_beat(spq_pkg::KIND_LIST, 2'd0, 8'h00);
    send_beat(spq_pkg::KIND_INSERT, spq_pkg::PRIO_NONE, 8'h55);
    send_beat(spq_pkg::KIND_REMOVE, 2'd3, 8'hFF);
    send_beat(spq_pkg::KIND_REMOVE, 2'd0, 8'h00);
    send_beat(spq_pkg::KIND_LIST, 2'd3, 8'hFF);
    send_beat(KIND_SPARE, 2'd0, 8'h00);
    repeat (6) send_beat(spq_pkg::KIND_REMOVE, 2'd1, 8'h01);
    send_beat(spq_pkg::KIND_LIST, 2'd1, 8'h01);
    pause_until_drained();

    // random: alternate fill and drain phases, overrun full and empty a little
    calm    = 1'b0;
    done    = 0;
    overrun = 0;
    filling = 1'b1;
    while (done < RANDOM_ITEMS) begin
      if (done == 120) hold_req = 1'b1;
      if (done == 240) pause_until_drained();
      if (filling) random_request(72, 13, k);
      else random_request(20, 66, k);
      if (k != KIND_SPARE) done++;
      if (filling && book.fill == DEPTH) overrun++;
      if (!filling && book.fill == 0) overrun++;
      if ((filling && overrun > 12) || (!filling && overrun > 4)) begin
        filling = !filling;
        overrun = 0;
      end
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.answers_due.size() == 0)
      $display("stable_priority_queue: match");
    else
      $display("stable_priority_queue: mismatch");
    $finish;
  end

endmodule
